// File: rtl/ibg_pkg.sv
// ----------------------------------------------------------------------------
// ibg_pkg
// Shared widths, types and operand codes for the IoU box grouper.
// ----------------------------------------------------------------------------
`default_nettype none

package ibg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int LABEL_BITS  = 8;
    localparam int COUNT_BITS  = 8;
    localparam int SCORE_BITS  = 16;
    localparam int THRESH_BITS = 16;

    // area of one box, and a sum of two areas
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNION_BITS = AREA_BITS + 1;

    // shared multiplier: wide operand carries the union or a horizontal extent,
    // narrow one a vertical extent or the threshold
    localparam int MUL_A_BITS = UNION_BITS;
    localparam int MUL_B_BITS = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET  = THRESH_BITS'(32768);

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } box_t;

    typedef enum logic [1:0] {
        OP_HEAD_AREA,
        OP_BOX_AREA,
        OP_INTER,
        OP_THRESH
    } op_sel_t;

    typedef struct packed {
        logic [MUL_A_BITS-1:0] a;
        logic [MUL_B_BITS-1:0] b;
    } mul_op_t;

endpackage

`default_nettype wire

// File: rtl/ibg_box_if.sv
// ----------------------------------------------------------------------------
// ibg_box_if / ibg_res_if
// Valid/ready channels for detection boxes and grouping results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibg_box_if import ibg_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] box_label;
    logic [SCORE_BITS-1:0] box_score;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_right;
    logic [COORD_BITS-1:0] box_bottom;

    modport source (
        output valid, box_label, box_score, box_left, box_top, box_right, box_bottom,
        input  ready
    );
    modport sink (
        input  valid, box_label, box_score, box_left, box_top, box_right, box_bottom,
        output ready
    );
endinterface

interface ibg_res_if import ibg_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic                  new_group;
    logic [LABEL_BITS-1:0] head_label;
    logic [SCORE_BITS-1:0] head_score;
    logic [COORD_BITS-1:0] head_left;
    logic [COORD_BITS-1:0] head_top;
    logic [COORD_BITS-1:0] head_right;
    logic [COORD_BITS-1:0] head_bottom;
    logic [COUNT_BITS-1:0] group_size;

    modport source (
        output valid, new_group, head_label, head_score, head_left, head_top,
               head_right, head_bottom, group_size,
        input  ready
    );
    modport sink (
        input  valid, new_group, head_label, head_score, head_left, head_top,
               head_right, head_bottom, group_size,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ibg_geom.sv
// ----------------------------------------------------------------------------
// ibg_geom
// Box geometry: clamped extents and overlap, muxed onto multiplier operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ibg_geom import ibg_pkg::*; (
    input  box_t                   head,
    input  box_t                   cur,
    input  logic [THRESH_BITS-1:0] threshold,
    input  logic [UNION_BITS-1:0]  union_area,
    input  op_sel_t                sel,
    output mul_op_t                op
);

    function automatic logic [COORD_BITS-1:0] extent(
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    logic [COORD_BITS-1:0] ov_left, ov_top, ov_right, ov_bottom;

    assign ov_left   = (head.left   > cur.left)   ? head.left   : cur.left;
    assign ov_top    = (head.top    > cur.top)    ? head.top    : cur.top;
    assign ov_right  = (head.right  < cur.right)  ? head.right  : cur.right;
    assign ov_bottom = (head.bottom < cur.bottom) ? head.bottom : cur.bottom;

    always_comb
    begin
        case (sel)
            OP_HEAD_AREA:
            begin
                op.a = MUL_A_BITS'(extent(head.left, head.right));
                op.b = MUL_B_BITS'(extent(head.top, head.bottom));
            end
            OP_BOX_AREA:
            begin
                op.a = MUL_A_BITS'(extent(cur.left, cur.right));
                op.b = MUL_B_BITS'(extent(cur.top, cur.bottom));
            end
            OP_INTER:
            begin
                op.a = MUL_A_BITS'(extent(ov_left, ov_right));
                op.b = MUL_B_BITS'(extent(ov_top, ov_bottom));
            end
            OP_THRESH:
            begin
                op.a = union_area;
                op.b = MUL_B_BITS'(threshold);
            end
            default:
            begin
                op.a = '0;
                op.b = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ibg_mul.sv
// ----------------------------------------------------------------------------
// ibg_mul
// Shared multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ibg_mul import ibg_pkg::*; (
    input  logic                 clk,
    input  mul_op_t              op,
    output logic [PROD_BITS-1:0] prod
);

    logic [PROD_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(op.a) * PROD_BITS'(op.b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/iou_box_grouper.sv
// Sequence: after an input beat the box steps through HEAD_AREA, BOX_AREA, INTER,
// UNION, THRESH and DECIDE (four multiplier passes, one union add, one decision).
// A new box is taken only back in IDLE, after the decision on the previous one.
// A result waiting at the output stalls only the decision cycle of the next box.
// Reset: rst_n is asynchronous, active low; no group is open afterwards and the
// IoU threshold returns to 0.5 (32768).
// ----------------------------------------------------------------------------
// iou_box_grouper
// Groups a box stream by label and IoU against the current group head.
// ----------------------------------------------------------------------------
`default_nettype none

module iou_box_grouper import ibg_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [THRESH_BITS-1:0] cfg_wr_data,
    ibg_box_if.sink                box_in,
    ibg_res_if.source              result_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_AREA,
        ST_BOX_AREA,
        ST_INTER,
        ST_UNION,
        ST_THRESH,
        ST_DECIDE
    } state_t;

    state_t                 state_reg, state_next;
    logic [THRESH_BITS-1:0] thresh_reg, thresh_next;

    logic                   open_reg, open_next;
    logic [LABEL_BITS-1:0]  lead_label_reg, lead_label_next;
    logic [SCORE_BITS-1:0]  lead_score_reg, lead_score_next;
    box_t                   lead_box_reg, lead_box_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic [LABEL_BITS-1:0]  cur_label_reg, cur_label_next;
    logic [SCORE_BITS-1:0]  cur_score_reg, cur_score_next;
    box_t                   cur_box_reg, cur_box_next;

    logic [AREA_BITS-1:0]   area_a_reg, area_a_next;
    logic [AREA_BITS-1:0]   area_b_reg, area_b_next;
    logic [AREA_BITS-1:0]   inter_reg, inter_next;
    logic [UNION_BITS-1:0]  union_reg, union_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_new_reg, out_new_next;

    op_sel_t                sel;
    mul_op_t                mul_op;
    logic [PROD_BITS-1:0]   prod;
    logic                   out_free;
    logic                   enough;
    logic                   start;

    ibg_geom u_geom (
        .head       (lead_box_reg),
        .cur        (cur_box_reg),
        .threshold  (thresh_reg),
        .union_area (union_reg),
        .sel        (sel),
        .op         (mul_op)
    );

    ibg_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    // operand select runs one state ahead of where the product is used
    always_comb
    begin
        case (state_reg)
            ST_HEAD_AREA: sel = OP_HEAD_AREA;
            ST_BOX_AREA:  sel = OP_BOX_AREA;
            ST_INTER:     sel = OP_INTER;
            ST_UNION:     sel = OP_INTER;
            default:      sel = OP_THRESH;
        endcase
    end

    assign out_free = !out_valid_reg || result_out.ready;
    assign enough   = PROD_BITS'({inter_reg, 16'b0}) >= prod;
    assign start    = !open_reg || (lead_label_reg != cur_label_reg) || !enough;

    always_comb
    begin
        state_next      = state_reg;
        thresh_next     = thresh_reg;
        open_next       = open_reg;
        lead_label_next = lead_label_reg;
        lead_score_next = lead_score_reg;
        lead_box_next   = lead_box_reg;
        count_next      = count_reg;
        cur_label_next  = cur_label_reg;
        cur_score_next  = cur_score_reg;
        cur_box_next    = cur_box_reg;
        area_a_next     = area_a_reg;
        area_b_next     = area_b_reg;
        inter_next      = inter_reg;
        union_next      = union_reg;
        out_valid_next  = out_valid_reg;
        out_new_next    = out_new_reg;

        if (cfg_wr_en)
        begin
            thresh_next = cfg_wr_data;
        end

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (box_in.valid)
                begin
                    cur_label_next    = box_in.box_label;
                    cur_score_next    = box_in.box_score;
                    cur_box_next.left   = box_in.box_left;
                    cur_box_next.top    = box_in.box_top;
                    cur_box_next.right  = box_in.box_right;
                    cur_box_next.bottom = box_in.box_bottom;
                    state_next        = ST_HEAD_AREA;
                end
            end
            ST_HEAD_AREA:
            begin
                state_next = ST_BOX_AREA;
            end
            ST_BOX_AREA:
            begin
                area_a_next = prod[AREA_BITS-1:0];
                state_next  = ST_INTER;
            end
            ST_INTER:
            begin
                area_b_next = prod[AREA_BITS-1:0];
                state_next  = ST_UNION;
            end
            ST_UNION:
            begin
                inter_next = prod[AREA_BITS-1:0];
                union_next = UNION_BITS'(area_a_reg) + UNION_BITS'(area_b_reg)
                           - UNION_BITS'(prod[AREA_BITS-1:0]);
                state_next = ST_THRESH;
            end
            ST_THRESH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    open_next      = 1'b1;
                    out_new_next   = start;
                    out_valid_next = 1'b1;
                    if (start)
                    begin
                        lead_label_next = cur_label_reg;
                        lead_score_next = cur_score_reg;
                        lead_box_next   = cur_box_reg;
                        count_next      = COUNT_BITS'(1);
                    end
                    else
                    begin
                        if (lead_score_reg < cur_score_reg)
                        begin
                            lead_score_next = cur_score_reg;
                            lead_box_next   = cur_box_reg;
                        end
                        if (count_reg < COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thresh_reg     <= THRESH_RESET;
            open_reg       <= 1'b0;
            lead_label_reg <= '0;
            lead_score_reg <= '0;
            lead_box_reg   <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_new_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thresh_reg     <= thresh_next;
            open_reg       <= open_next;
            lead_label_reg <= lead_label_next;
            lead_score_reg <= lead_score_next;
            lead_box_reg   <= lead_box_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_new_reg    <= out_new_next;
        end
    end

    // working registers of the current box, no reset needed
    always_ff @(posedge clk)
    begin
        cur_label_reg <= cur_label_next;
        cur_score_reg <= cur_score_next;
        cur_box_reg   <= cur_box_next;
        area_a_reg    <= area_a_next;
        area_b_reg    <= area_b_next;
        inter_reg     <= inter_next;
        union_reg     <= union_next;
    end

    assign box_in.ready = (state_reg == ST_IDLE);

    // head state doubles as the output register
    assign result_out.valid       = out_valid_reg;
    assign result_out.new_group   = out_new_reg;
    assign result_out.head_label  = lead_label_reg;
    assign result_out.head_score  = lead_score_reg;
    assign result_out.head_left   = lead_box_reg.left;
    assign result_out.head_top    = lead_box_reg.top;
    assign result_out.head_right  = lead_box_reg.right;
    assign result_out.head_bottom = lead_box_reg.bottom;
    assign result_out.group_size  = count_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        box_in.valid && box_in.ready |=> !box_in.ready)
        else $error("input taken again while a box is in flight");

    a_new_group_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.new_group |-> count_reg == COUNT_BITS'(1))
        else $error("new group beat with group size not one");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> open_reg && count_reg != '0)
        else $error("result beat without an open group");

    a_decide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE && out_valid_reg && !result_out.ready
        |=> state_reg == ST_DECIDE)
        else $error("decision taken while the output beat is stalled");
`endif

endmodule

`default_nettype wire
